@@ rtl/udp_socket_demux_table_macros.svh @@
`ifndef UDP_SOCKET_DEMUX_TABLE_MACROS_SVH
`define UDP_SOCKET_DEMUX_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define UDPDT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("udp socket demux check failed");

// next-cycle implication, checked outside reset
`define UDPDT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("udp socket demux check failed");

`endif

@@ rtl/udpdt_pkg.sv @@
`timescale 1ns / 1ps
package udpdt_pkg;

	localparam logic [2:0] OP_BIND    = 3'd0;
	localparam logic [2:0] OP_CONNECT = 3'd1;
	localparam logic [2:0] OP_UNBIND  = 3'd2;
	localparam logic [2:0] OP_PACKET  = 3'd3;
	localparam logic [2:0] OP_ICMP    = 3'd4;

	localparam logic [3:0] K_DELIVER    = 4'd0;
	localparam logic [3:0] K_UNREACH    = 4'd1;
	localparam logic [3:0] K_UNREACH_MC = 4'd2;
	localparam logic [3:0] K_BAD_CSUM   = 4'd3;
	localparam logic [3:0] K_NOTIFY     = 4'd4;
	localparam logic [3:0] K_IGNORED    = 4'd5;
	localparam logic [3:0] K_BOUND      = 4'd6;
	localparam logic [3:0] K_CONNECTED  = 4'd7;
	localparam logic [3:0] K_UNBOUND    = 4'd8;
	localparam logic [3:0] K_FAULT      = 4'd9;

	localparam logic       REG_EPH_FIRST = 1'b0;
	localparam logic       REG_EPH_END   = 1'b1;

	localparam logic [15:0] EPH_FIRST_RST = 16'd1024;
	localparam logic [15:0] EPH_END_RST   = 16'd5000;
	localparam logic [8:0]  IFACE_ANY     = 9'h1FF;
	localparam logic [4:0]  RESULT_LIMIT  = 5'd16;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] sock_id;
		logic [15:0] user_id;
		logic [5:0]  app_gate;
		logic [31:0] local_addr;
		logic [31:0] remote_addr;
		logic [15:0] local_port;
		logic [15:0] remote_port;
		logic [8:0]  interface_id;
		logic        bit_error;
	} req_t;

	typedef struct packed {
		logic [15:0] sock_id;
		logic [15:0] user_id;
		logic [5:0]  gate;
		logic [31:0] local_addr;
		logic [31:0] remote_addr;
		logic [15:0] local_port;
		logic [15:0] remote_port;
		logic [8:0]  iface;
		logic        wild;
	} entry_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] sock_id;
		logic [15:0] user_id;
		logic [5:0]  gate;
		logic [15:0] local_port;
		logic        last;
	} res_t;

	function automatic logic [15:0] next_cand(logic [15:0] c, logic [15:0] first,
		logic [15:0] stop);
		logic [15:0] n;
		n = c + 16'd1;
		return (n == stop) ? first : n;
	endfunction

endpackage

@@ rtl/udpdt_req_if.sv @@
`timescale 1ns / 1ps
interface udpdt_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        op;
	logic [15:0]       sock_id;
	logic [15:0]       user_id;
	logic [5:0]        app_gate;
	logic [31:0]       local_addr;
	logic [31:0]       remote_addr;
	logic [15:0]       local_port;
	logic [15:0]       remote_port;
	logic signed [8:0] interface_id;
	logic              bit_error;

	modport source (output valid, op, sock_id, user_id, app_gate, local_addr, remote_addr,
		local_port, remote_port, interface_id, bit_error, input ready);
	modport sink (input valid, op, sock_id, user_id, app_gate, local_addr, remote_addr,
		local_port, remote_port, interface_id, bit_error, output ready);
endinterface

@@ rtl/udpdt_res_if.sv @@
`timescale 1ns / 1ps
interface udpdt_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [15:0] out_sock_id;
	logic [15:0] out_user_id;
	logic [5:0]  out_gate;
	logic [15:0] out_local_port;
	logic        last;

	modport source (output valid, kind, out_sock_id, out_user_id, out_gate, out_local_port,
		last, input ready);
	modport sink (input valid, kind, out_sock_id, out_user_id, out_gate, out_local_port,
		last, output ready);
endinterface

@@ rtl/udpdt_ram.sv @@
`timescale 1ns / 1ps
module udpdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ rtl/udp_socket_demux_table.sv @@
`timescale 1ns / 1ps
// udp socket demultiplexer table
// req channel: one request per command (bind, connect, unbind) or per received
// packet or icmp error report; res channel: one or more results, last marks the
// final one of a request. cfg_we/cfg_idx/cfg_data set the ephemeral port range.
// the table sits in one ram with a registered read; every request but a
// bad-checksum packet or an unknown op scans the bound entries, each one read
// and then evaluated. a bind with local port 0 rescans once per ephemeral
// candidate tried, up to SOCKETS+2 rescans; an unbind shifts each entry behind
// the removed one down by a read and a write.
// one request is worked on at a time; req.ready is high only while idle.
// a finished result waits in an output register, so the next request is taken
// while that result is still unread. when the receiver stalls, the scan halts
// at the next delivery until the output register frees.
// reset empties the table, restores the range to 1024..4999 (end 5000 is
// exclusive) and the last ephemeral port to 1024; ram contents are left as they are.
module udp_socket_demux_table #(
	parameter int SOCKETS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	udpdt_req_if.sink    req,
	udpdt_res_if.source  res,
	input  logic         cfg_we,
	input  logic         cfg_idx,
	input  logic [15:0]  cfg_data
);
	localparam int IW = SOCKETS > 1 ? $clog2(SOCKETS) : 1;
	localparam int CW = $clog2(SOCKETS + 1);
	localparam int TW = $clog2(SOCKETS + 2);
	localparam int EW = $bits(udpdt_pkg::entry_t);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EV   = 3'd2;
	localparam logic [2:0] S_DONE = 3'd3;
	localparam logic [2:0] S_SHR  = 3'd4;
	localparam logic [2:0] S_SHW  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]          state_q;
	udpdt_pkg::req_t     req_q;
	logic [CW-1:0]       count_q, idx_q;
	logic                hit_q, phase_q, used_q, pend_v_q, out_v_q;
	logic [IW-1:0]       hidx_q;
	udpdt_pkg::entry_t   hdat_q;
	logic [15:0]         cand_q, last_eph_q, first_q, end_q;
	logic [TW-1:0]       tries_q;
	logic [4:0]          cnt_q;
	udpdt_pkg::res_t     pend_q, fin_q, out_q;

	logic                we;
	logic [IW-1:0]       waddr, raddr;
	udpdt_pkg::entry_t   wdata, cur;
	logic [EW-1:0]       rdata;
	logic                can_push, lp_eq, addr_ok, pkt_m, icmp_m, pkt_take, push_pend, push_fin;
	logic                bind_fault0, bind_commit;
	logic [15:0]         bind_port;
	udpdt_pkg::req_t     req_in;
	udpdt_pkg::res_t     fault_res;

	udpdt_ram #(.WIDTH(EW), .DEPTH(SOCKETS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign req_in = '{op: req.op, sock_id: req.sock_id, user_id: req.user_id,
		app_gate: req.app_gate, local_addr: req.local_addr, remote_addr: req.remote_addr,
		local_port: req.local_port, remote_port: req.remote_port,
		interface_id: req.interface_id, bit_error: req.bit_error};

	assign cur = udpdt_pkg::entry_t'(rdata);
	assign can_push = !out_v_q || res.ready;
	assign req.ready = (state_q == S_IDLE);

	assign lp_eq = (cur.local_port == req_q.local_port);
	assign addr_ok = (cur.remote_port == 16'd0 || cur.remote_port == req_q.remote_port)
		&& (cur.local_addr == 32'd0 || cur.local_addr == req_q.local_addr)
		&& (cur.remote_addr == 32'd0 || cur.remote_addr == req_q.remote_addr);
	assign icmp_m = lp_eq && (cur.wild || addr_ok);
	assign pkt_m = lp_eq && (cur.wild || (addr_ok
		&& (cur.iface == udpdt_pkg::IFACE_ANY || cur.iface == req_q.interface_id)));
	assign pkt_take = (state_q == S_EV) && (req_q.op == udpdt_pkg::OP_PACKET) && pkt_m
		&& (cnt_q < udpdt_pkg::RESULT_LIMIT);
	assign push_pend = pkt_take && pend_v_q && can_push;
	assign push_fin = (state_q == S_OUT) && can_push;

	assign bind_fault0 = hit_q || (count_q == CW'(SOCKETS));
	assign bind_port = phase_q ? cand_q : req_q.local_port;
	assign bind_commit = (state_q == S_DONE) && (req_q.op == udpdt_pkg::OP_BIND)
		&& (phase_q ? !used_q : (!bind_fault0 && req_q.local_port != 16'd0));
	assign fault_res = '{kind: udpdt_pkg::K_FAULT, sock_id: req_q.sock_id,
		user_id: 16'd0, gate: 6'd0, local_port: 16'd0, last: 1'b1};

	always_comb begin
		raddr = (state_q == S_SHR) ? IW'(idx_q + 1'b1) : idx_q[IW-1:0];
		we = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = cur;
		if (state_q == S_SHW) begin
			we = 1'b1;
		end else if (bind_commit) begin
			we = 1'b1;
			waddr = count_q[IW-1:0];
			wdata = '{sock_id: req_q.sock_id, user_id: req_q.user_id, gate: req_q.app_gate,
				local_addr: req_q.local_addr, remote_addr: req_q.remote_addr,
				local_port: bind_port, remote_port: req_q.remote_port,
				iface: req_q.interface_id,
				wild: req_q.local_addr == 32'd0 && req_q.remote_addr == 32'd0
					&& req_q.remote_port == 16'd0 && req_q.interface_id == udpdt_pkg::IFACE_ANY};
		end else if (state_q == S_DONE && req_q.op == udpdt_pkg::OP_CONNECT && hit_q
			&& req_q.remote_addr != 32'd0 && req_q.remote_port != 16'd0) begin
			we = 1'b1;
			waddr = hidx_q;
			wdata = hdat_q;
			wdata.remote_addr = req_q.remote_addr;
			wdata.remote_port = req_q.remote_port;
			wdata.wild = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= udpdt_pkg::EPH_FIRST_RST;
			end_q <= udpdt_pkg::EPH_END_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				udpdt_pkg::REG_EPH_FIRST: first_q <= cfg_data;
				udpdt_pkg::REG_EPH_END:   end_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push_fin || push_pend) begin
			out_v_q <= 1'b1;
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_fin) begin
			out_q <= fin_q;
		end else if (push_pend) begin
			out_q <= pend_q;
		end
	end

	assign res.valid = out_v_q;
	assign res.kind = out_q.kind;
	assign res.out_sock_id = out_q.sock_id;
	assign res.out_user_id = out_q.user_id;
	assign res.out_gate = out_q.gate;
	assign res.out_local_port = out_q.local_port;
	assign res.last = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			last_eph_q <= udpdt_pkg::EPH_FIRST_RST;
			idx_q <= '0;
			hit_q <= 1'b0;
			phase_q <= 1'b0;
			used_q <= 1'b0;
			pend_v_q <= 1'b0;
			cnt_q <= '0;
			tries_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_q <= req_in;
						idx_q <= '0;
						hit_q <= 1'b0;
						phase_q <= 1'b0;
						used_q <= 1'b0;
						pend_v_q <= 1'b0;
						cnt_q <= '0;
						if (req.op == udpdt_pkg::OP_PACKET && req.bit_error) begin
							fin_q <= '{kind: udpdt_pkg::K_BAD_CSUM, sock_id: 16'd0,
								user_id: 16'd0, gate: 6'd0, local_port: 16'd0, last: 1'b1};
							state_q <= S_OUT;
						end else if (req.op > udpdt_pkg::OP_ICMP) begin
							fin_q <= '{kind: udpdt_pkg::K_FAULT, sock_id: req.sock_id,
								user_id: 16'd0, gate: 6'd0, local_port: 16'd0, last: 1'b1};
							state_q <= S_OUT;
						end else begin
							state_q <= (count_q == '0) ? S_DONE : S_RD;
						end
					end
				end
				S_RD: state_q <= S_EV;
				S_EV: begin
					if (!(pkt_take && pend_v_q && !can_push)) begin
						case (req_q.op)
							udpdt_pkg::OP_BIND, udpdt_pkg::OP_CONNECT, udpdt_pkg::OP_UNBIND: begin
								if (phase_q) begin
									if (cur.local_port == cand_q) used_q <= 1'b1;
								end else if (cur.sock_id == req_q.sock_id && !hit_q) begin
									hit_q <= 1'b1;
									hidx_q <= idx_q[IW-1:0];
									hdat_q <= cur;
								end
							end
							udpdt_pkg::OP_PACKET: begin
								if (pkt_take) begin
									pend_v_q <= 1'b1;
									pend_q <= '{kind: udpdt_pkg::K_DELIVER, sock_id: cur.sock_id,
										user_id: cur.user_id, gate: cur.gate,
										local_port: cur.local_port, last: 1'b0};
									cnt_q <= cnt_q + 5'd1;
								end
							end
							udpdt_pkg::OP_ICMP: begin
								if (icmp_m) begin
									hit_q <= 1'b1;
									hdat_q <= cur;
								end
							end
							default: ;
						endcase
						idx_q <= idx_q + 1'b1;
						state_q <= (idx_q + 1'b1 == count_q) ? S_DONE : S_RD;
					end
				end
				S_DONE: begin
					case (req_q.op)
						udpdt_pkg::OP_BIND: begin
							if (bind_commit) begin
								count_q <= count_q + 1'b1;
								if (phase_q) last_eph_q <= cand_q;
								fin_q <= '{kind: udpdt_pkg::K_BOUND, sock_id: req_q.sock_id,
									user_id: req_q.user_id, gate: req_q.app_gate,
									local_port: bind_port, last: 1'b1};
								state_q <= S_OUT;
							end else if ((!phase_q && bind_fault0) || (phase_q
								&& (cand_q == last_eph_q || tries_q > TW'(SOCKETS)))) begin
								fin_q <= fault_res;
								state_q <= S_OUT;
							end else begin
								if (phase_q) begin
									tries_q <= tries_q + 1'b1;
									cand_q <= udpdt_pkg::next_cand(cand_q, first_q, end_q);
								end else begin
									tries_q <= '0;
									cand_q <= udpdt_pkg::next_cand(last_eph_q, first_q, end_q);
								end
								phase_q <= 1'b1;
								used_q <= 1'b0;
								idx_q <= '0;
								state_q <= (count_q == '0) ? S_DONE : S_RD;
							end
						end
						udpdt_pkg::OP_CONNECT: begin
							state_q <= S_OUT;
							if (we) begin
								fin_q <= '{kind: udpdt_pkg::K_CONNECTED, sock_id: hdat_q.sock_id,
									user_id: hdat_q.user_id, gate: hdat_q.gate,
									local_port: hdat_q.local_port, last: 1'b1};
							end else begin
								fin_q <= fault_res;
							end
						end
						udpdt_pkg::OP_UNBIND: begin
							if (hit_q) begin
								fin_q <= '{kind: udpdt_pkg::K_UNBOUND, sock_id: hdat_q.sock_id,
									user_id: hdat_q.user_id, gate: hdat_q.gate,
									local_port: hdat_q.local_port, last: 1'b1};
								idx_q <= CW'(hidx_q);
								if (CW'(hidx_q) + 1'b1 < count_q) begin
									state_q <= S_SHR;
								end else begin
									count_q <= count_q - 1'b1;
									state_q <= S_OUT;
								end
							end else begin
								fin_q <= fault_res;
								state_q <= S_OUT;
							end
						end
						udpdt_pkg::OP_PACKET: begin
							state_q <= S_OUT;
							if (pend_v_q) begin
								fin_q <= '{kind: pend_q.kind, sock_id: pend_q.sock_id,
									user_id: pend_q.user_id, gate: pend_q.gate,
									local_port: pend_q.local_port, last: 1'b1};
							end else begin
								fin_q <= '{kind: (req_q.local_addr[31:28] == 4'hE) ?
									udpdt_pkg::K_UNREACH_MC : udpdt_pkg::K_UNREACH,
									sock_id: 16'd0, user_id: 16'd0, gate: 6'd0,
									local_port: req_q.local_port, last: 1'b1};
							end
						end
						default: begin
							state_q <= S_OUT;
							if (hit_q) begin
								fin_q <= '{kind: udpdt_pkg::K_NOTIFY, sock_id: hdat_q.sock_id,
									user_id: hdat_q.user_id, gate: hdat_q.gate,
									local_port: hdat_q.local_port, last: 1'b1};
							end else begin
								fin_q <= '{kind: udpdt_pkg::K_IGNORED, sock_id: 16'd0,
									user_id: 16'd0, gate: 6'd0, local_port: 16'd0, last: 1'b1};
							end
						end
					endcase
				end
				S_SHR: state_q <= S_SHW;
				S_SHW: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q + 2'd2 < count_q) begin
						state_q <= S_SHR;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (can_push) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/udpdt_chk.sv @@
`timescale 1ns / 1ps
`include "udp_socket_demux_table_macros.svh"
module udpdt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [3:0]  kind,
	input logic [15:0] out_sock_id,
	input logic [15:0] out_user_id,
	input logic        last
);
	// a stalled result holds
	`UDPDT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(kind))
	// only deliveries may be followed by more results of the same request
	`UDPDT_ASSERT_NOW(a_single_last, res_valid && kind != udpdt_pkg::K_DELIVER, last)
	// one request at a time
	`UDPDT_ASSERT_NEXT(a_one_req, req_valid && req_ready, !req_ready)
	// results without a socket carry no identity
	`UDPDT_ASSERT_NOW(a_no_sock, res_valid && (kind == udpdt_pkg::K_UNREACH
		|| kind == udpdt_pkg::K_BAD_CSUM || kind == udpdt_pkg::K_IGNORED),
		out_sock_id == 16'd0 && out_user_id == 16'd0)
endmodule

bind udp_socket_demux_table udpdt_chk u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.res_valid(res.valid), .res_ready(res.ready), .kind(res.kind),
	.out_sock_id(res.out_sock_id), .out_user_id(res.out_user_id), .last(res.last)
);
